@@ hdl/mcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metaball colour field package
// Widths, register map, reset values and field helpers shared by the block.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIX_W  = 12;
  localparam int EXT_W  = 16;          // pixel widened before masking
  localparam int RCP_W  = 24;
  localparam int NORM_W = 13;
  localparam logic [NORM_W-1:0] NORM_MAX = 13'h1FFF;

  localparam int NBLOB  = 3;
  localparam int BLOB_W = 50;
  localparam int IRS_W  = 16;
  localparam int AS_W   = 16;
  localparam int CH_W   = 8;

  localparam int D2_W   = 27;          // Q3.24 squared distance
  localparam int T_W    = 43;          // Q8.35 scaled distance
  localparam int ONE_B  = 35;          // bit position of 1.0 in t
  localparam int S_W    = 17;          // strength, Q0.16 with 1.0 representable
  localparam int SQ_W   = 34;
  localparam int W_W    = 17;
  localparam int PROD_W = 25;
  localparam int ACC_W  = 27;
  localparam int EN_W   = 19;
  localparam int FAC_W  = 33;
  localparam int AP_W   = 49;

  localparam logic [CH_W-1:0] BASE_R = 8'd6;
  localparam logic [CH_W-1:0] BASE_G = 8'd12;
  localparam logic [CH_W-1:0] BASE_B = 8'd22;
  localparam logic [W_W-1:0]  ONE_Q16 = 17'd65536;
  localparam logic [15:0]     K045 = 16'd29491;
  localparam logic [15:0]     K055 = 16'd36045;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // APB register map, one 64-bit slot per register
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_BLOB_A   = 3'd0;
  localparam logic [IDX_W-1:0] REG_BLOB_B   = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLOB_C   = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_RSQ  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALPHA_SC = 3'd4;
  localparam logic [IDX_W-1:0] REG_RCP_W    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RCP_H    = 3'd6;

  localparam logic [IRS_W-1:0] IRS_RST = 16'd39014;
  localparam logic [AS_W-1:0]  AS_RST  = 16'd13056;
  localparam logic [RCP_W-1:0] RCP_RST = 24'd16384;

  typedef struct packed {
    logic [NBLOB-1:0][BLOB_W-1:0] blob;
    logic [IRS_W-1:0]             inv_radius_sq;
    logic [AS_W-1:0]              alpha_scale;
    logic [RCP_W-1:0]             recip_width;
    logic [RCP_W-1:0]             recip_height;
  } cfg_t;

  function automatic logic [NORM_W-1:0] blob_cx(input logic [BLOB_W-1:0] b);
    return b[12:0];
  endfunction

  function automatic logic [NORM_W-1:0] blob_cy(input logic [BLOB_W-1:0] b);
    return b[25:13];
  endfunction

  function automatic logic [CH_W-1:0] blob_red(input logic [BLOB_W-1:0] b);
    return b[49:42];
  endfunction

  function automatic logic [CH_W-1:0] blob_green(input logic [BLOB_W-1:0] b);
    return b[41:34];
  endfunction

  function automatic logic [CH_W-1:0] blob_blue(input logic [BLOB_W-1:0] b);
    return b[33:26];
  endfunction

endpackage

@@ hdl/mcf_pix_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel coordinate channel
// Valid/ready channel carrying one pixel column and row per beat.
// ----------------------------------------------------------------------------
interface mcf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [mcf_pkg::PIX_W-1:0] pix_x;
  logic [mcf_pkg::PIX_W-1:0] pix_y;

  modport source (output valid, output pix_x, output pix_y, input ready);
  modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

@@ hdl/mcf_rgba_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlay colour channel
// Valid/ready channel carrying one alpha/red/green/blue pixel per beat.
// ----------------------------------------------------------------------------
interface mcf_rgba_if;
  logic                     valid;
  logic                     ready;
  logic [mcf_pkg::CH_W-1:0] alpha_out;
  logic [mcf_pkg::CH_W-1:0] red_out;
  logic [mcf_pkg::CH_W-1:0] green_out;
  logic [mcf_pkg::CH_W-1:0] blue_out;

  modport source (output valid, output alpha_out, output red_out, output green_out,
                  output blue_out, input ready);
  modport sink   (input valid, input alpha_out, input red_out, input green_out,
                  input blue_out, output ready);
endinterface

@@ hdl/metaball_color_field_pixel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metaball colour field pixel pipeline
// Throughput: one pixel per cycle unless the output stalls the stages; each of the eight stages holds one pixel.
// A stage advances when it is empty or the stage after it advances.
// Reset clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module metaball_color_field_pixel_top #(
  parameter int COORD_BITS = mcf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcf_pkg::APB_AW-1:0]   paddr,
  input  logic [mcf_pkg::APB_DW-1:0]   pwdata,
  output logic [mcf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  mcf_pix_if.sink                      in_pix_i,
  mcf_rgba_if.source                   out_rgba_o
);

  localparam int NST   = 8;
  localparam int NP_W  = COORD_BITS + mcf_pkg::RCP_W;   // pixel times reciprocal
  localparam int NS_W  = NP_W - 12;                     // after dropping 12 bits

  mcf_pkg::cfg_t cfg;

  mcf_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q, vld_d;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = out_rgba_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_pix_i.valid : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_pix_i.ready   = adv[0];
  assign out_rgba_o.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: normalise coordinates to Q1.12
  // --------------------------------------------------------------------------
  logic [mcf_pkg::EXT_W-1:0]  px_ext, py_ext;
  logic [NP_W-1:0]            px_prod, py_prod;
  logic [NS_W-1:0]            px_n, py_n;
  logic [mcf_pkg::NORM_W-1:0] nx_d, ny_d, nx_q, ny_q;

  always_comb begin
    px_ext  = mcf_pkg::EXT_W'(in_pix_i.pix_x);
    py_ext  = mcf_pkg::EXT_W'(in_pix_i.pix_y);
    px_prod = NP_W'(px_ext[COORD_BITS-1:0]) * NP_W'(cfg.recip_width);
    py_prod = NP_W'(py_ext[COORD_BITS-1:0]) * NP_W'(cfg.recip_height);
    px_n    = px_prod[NP_W-1:12];
    py_n    = py_prod[NP_W-1:12];
    // saturate anything at or beyond 2.0
    nx_d = (|px_n[NS_W-1:mcf_pkg::NORM_W]) ? mcf_pkg::NORM_MAX
                                            : px_n[mcf_pkg::NORM_W-1:0];
    ny_d = (|py_n[NS_W-1:mcf_pkg::NORM_W]) ? mcf_pkg::NORM_MAX
                                            : py_n[mcf_pkg::NORM_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 1: squared distance per blob
  // --------------------------------------------------------------------------
  logic [mcf_pkg::NBLOB-1:0][mcf_pkg::D2_W-1:0] d2_d, d2_q;

  always_comb begin
    for (int i = 0; i < mcf_pkg::NBLOB; i++) begin
      logic [mcf_pkg::NORM_W-1:0] cx, cy, ax, ay;
      logic [mcf_pkg::D2_W-1:0]   axe, aye;
      cx  = mcf_pkg::blob_cx(cfg.blob[i]);
      cy  = mcf_pkg::blob_cy(cfg.blob[i]);
      ax  = (nx_q >= cx) ? nx_q - cx : cx - nx_q;
      ay  = (ny_q >= cy) ? ny_q - cy : cy - ny_q;
      axe = mcf_pkg::D2_W'(ax);
      aye = mcf_pkg::D2_W'(ay);
      d2_d[i] = axe * axe + aye * aye;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by inverse radius squared
  // --------------------------------------------------------------------------
  logic [mcf_pkg::NBLOB-1:0][mcf_pkg::T_W-1:0] t_d, t_q;

  always_comb begin
    for (int i = 0; i < mcf_pkg::NBLOB; i++) begin
      t_d[i] = mcf_pkg::T_W'(d2_q[i]) * mcf_pkg::T_W'(cfg.inv_radius_sq);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: strength and its square
  // --------------------------------------------------------------------------
  logic [mcf_pkg::NBLOB-1:0][mcf_pkg::W_W-1:0] w_d, w_q;

  always_comb begin
    for (int i = 0; i < mcf_pkg::NBLOB; i++) begin
      logic [mcf_pkg::ONE_B:0]   diff;
      logic [mcf_pkg::S_W-1:0]   s;
      logic [mcf_pkg::SQ_W-1:0]  sq;
      logic                      skip;
      skip = |t_q[i][mcf_pkg::T_W-1:mcf_pkg::ONE_B];
      diff = {1'b1, {mcf_pkg::ONE_B{1'b0}}} - {1'b0, t_q[i][mcf_pkg::ONE_B-1:0]};
      s    = diff[mcf_pkg::ONE_B:19];
      sq   = mcf_pkg::SQ_W'(s) * mcf_pkg::SQ_W'(s);
      w_d[i] = skip ? '0 : sq[32:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: colour times weight
  // --------------------------------------------------------------------------
  logic [mcf_pkg::NBLOB-1:0][mcf_pkg::PROD_W-1:0] pr_d, pg_d, pb_d, pr_q, pg_q, pb_q;
  logic [mcf_pkg::NBLOB-1:0][mcf_pkg::W_W-1:0]    w4_q;

  always_comb begin
    for (int i = 0; i < mcf_pkg::NBLOB; i++) begin
      pr_d[i] = mcf_pkg::PROD_W'(mcf_pkg::blob_red(cfg.blob[i]))
              * mcf_pkg::PROD_W'(w_q[i]);
      pg_d[i] = mcf_pkg::PROD_W'(mcf_pkg::blob_green(cfg.blob[i]))
              * mcf_pkg::PROD_W'(w_q[i]);
      pb_d[i] = mcf_pkg::PROD_W'(mcf_pkg::blob_blue(cfg.blob[i]))
              * mcf_pkg::PROD_W'(w_q[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: accumulate, saturate channels, cap energy
  // --------------------------------------------------------------------------
  logic [mcf_pkg::ACC_W-1:0] acc_r, acc_g, acc_b;
  logic [mcf_pkg::EN_W-1:0]  en_sum;
  logic [mcf_pkg::CH_W-1:0]  r_d, g_d, b_d, r5_q, g5_q, b5_q;
  logic [mcf_pkg::W_W-1:0]   en_d, en_q;

  function automatic logic [mcf_pkg::CH_W-1:0] sat_ch(input logic [mcf_pkg::ACC_W-1:0] a);
    return (|a[mcf_pkg::ACC_W-1:24]) ? mcf_pkg::CH_MAX : a[23:16];
  endfunction

  always_comb begin
    acc_r  = mcf_pkg::ACC_W'(mcf_pkg::BASE_R) << 16;
    acc_g  = mcf_pkg::ACC_W'(mcf_pkg::BASE_G) << 16;
    acc_b  = mcf_pkg::ACC_W'(mcf_pkg::BASE_B) << 16;
    en_sum = '0;
    for (int i = 0; i < mcf_pkg::NBLOB; i++) begin
      acc_r  = acc_r + mcf_pkg::ACC_W'(pr_q[i]);
      acc_g  = acc_g + mcf_pkg::ACC_W'(pg_q[i]);
      acc_b  = acc_b + mcf_pkg::ACC_W'(pb_q[i]);
      en_sum = en_sum + mcf_pkg::EN_W'(w4_q[i]);
    end
    r_d  = sat_ch(acc_r);
    g_d  = sat_ch(acc_g);
    b_d  = sat_ch(acc_b);
    en_d = (en_sum > mcf_pkg::EN_W'(mcf_pkg::ONE_Q16)) ? mcf_pkg::ONE_Q16
                                                       : en_sum[mcf_pkg::W_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 6: opacity factor; stage 7: alpha
  // --------------------------------------------------------------------------
  logic [mcf_pkg::FAC_W-1:0] fac_d, fac_q;
  logic [mcf_pkg::CH_W-1:0]  r6_q, g6_q, b6_q;
  logic [mcf_pkg::AP_W-1:0]  ap;
  logic [mcf_pkg::CH_W-1:0]  a_d, a7_q, r7_q, g7_q, b7_q;

  always_comb begin
    fac_d = (mcf_pkg::FAC_W'(mcf_pkg::K045) << 16)
          + mcf_pkg::FAC_W'(mcf_pkg::K055) * mcf_pkg::FAC_W'(en_q);
    ap    = mcf_pkg::AP_W'(cfg.alpha_scale) * mcf_pkg::AP_W'(fac_q);
    a_d   = ap[mcf_pkg::AP_W-1] ? mcf_pkg::CH_MAX : ap[47:40];
  end

  // --------------------------------------------------------------------------
  // Payload registers: load when the stage advances
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
    if (adv[1]) begin
      d2_q <= d2_d;
    end
    if (adv[2]) begin
      t_q <= t_d;
    end
    if (adv[3]) begin
      w_q <= w_d;
    end
    if (adv[4]) begin
      pr_q <= pr_d;
      pg_q <= pg_d;
      pb_q <= pb_d;
      w4_q <= w_q;
    end
    if (adv[5]) begin
      r5_q <= r_d;
      g5_q <= g_d;
      b5_q <= b_d;
      en_q <= en_d;
    end
    if (adv[6]) begin
      fac_q <= fac_d;
      r6_q  <= r5_q;
      g6_q  <= g5_q;
      b6_q  <= b5_q;
    end
    if (adv[7]) begin
      a7_q <= a_d;
      r7_q <= r6_q;
      g7_q <= g6_q;
      b7_q <= b6_q;
    end
  end

  assign out_rgba_o.alpha_out = a7_q;
  assign out_rgba_o.red_out   = r7_q;
  assign out_rgba_o.green_out = g7_q;
  assign out_rgba_o.blue_out  = b7_q;

endmodule

@@ hdl/mcf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metaball colour field register file
// APB slave holding blob descriptors, radius, opacity and frame reciprocals.
// ----------------------------------------------------------------------------
module mcf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcf_pkg::APB_AW-1:0]   paddr,
  input  logic [mcf_pkg::APB_DW-1:0]   pwdata,
  output logic [mcf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output mcf_pkg::cfg_t                cfg_o
);

  mcf_pkg::cfg_t                   cfg_q, cfg_d;
  logic [mcf_pkg::IDX_W-1:0]       idx;
  logic                            wr_en;

  assign idx    = paddr[mcf_pkg::APB_AW-1:mcf_pkg::APB_AW-mcf_pkg::IDX_W];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mcf_pkg::REG_BLOB_A:   cfg_d.blob[0] = pwdata[mcf_pkg::BLOB_W-1:0];
        mcf_pkg::REG_BLOB_B:   cfg_d.blob[1] = pwdata[mcf_pkg::BLOB_W-1:0];
        mcf_pkg::REG_BLOB_C:   cfg_d.blob[2] = pwdata[mcf_pkg::BLOB_W-1:0];
        mcf_pkg::REG_INV_RSQ:  cfg_d.inv_radius_sq = pwdata[mcf_pkg::IRS_W-1:0];
        mcf_pkg::REG_ALPHA_SC: cfg_d.alpha_scale = pwdata[mcf_pkg::AS_W-1:0];
        mcf_pkg::REG_RCP_W:    cfg_d.recip_width = pwdata[mcf_pkg::RCP_W-1:0];
        mcf_pkg::REG_RCP_H:    cfg_d.recip_height = pwdata[mcf_pkg::RCP_W-1:0];
        default: ;             // unmapped slot: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mcf_pkg::REG_BLOB_A:   prdata = mcf_pkg::APB_DW'(cfg_q.blob[0]);
      mcf_pkg::REG_BLOB_B:   prdata = mcf_pkg::APB_DW'(cfg_q.blob[1]);
      mcf_pkg::REG_BLOB_C:   prdata = mcf_pkg::APB_DW'(cfg_q.blob[2]);
      mcf_pkg::REG_INV_RSQ:  prdata = mcf_pkg::APB_DW'(cfg_q.inv_radius_sq);
      mcf_pkg::REG_ALPHA_SC: prdata = mcf_pkg::APB_DW'(cfg_q.alpha_scale);
      mcf_pkg::REG_RCP_W:    prdata = mcf_pkg::APB_DW'(cfg_q.recip_width);
      mcf_pkg::REG_RCP_H:    prdata = mcf_pkg::APB_DW'(cfg_q.recip_height);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blob          <= '0;
      cfg_q.inv_radius_sq <= mcf_pkg::IRS_RST;
      cfg_q.alpha_scale   <= mcf_pkg::AS_RST;
      cfg_q.recip_width   <= mcf_pkg::RCP_RST;
      cfg_q.recip_height  <= mcf_pkg::RCP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
